[rtl/bwr_pkg.sv]
// Shared constants and types for the blend weight renormalizer.
`default_nettype none

package bwr_pkg;

   localparam int NUM_CH  = 8;
   localparam int CH_BITS = 3;

   typedef logic [CH_BITS-1:0] ch_idx_type;

endpackage

`default_nettype wire

[rtl/bwr_front.sv]
// Front pipeline: clamp and remainder, then weight sum and scaling products.
`default_nettype none

module bwr_front import bwr_pkg::*; #(
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output logic                                        in_ready,
   input  wire ch_idx_type                             in_tgt,
   input  wire logic [WEIGHT_BITS-1:0]                 in_new_value,
   input  wire logic [NUM_CH-1:0][WEIGHT_BITS-1:0]     in_weight,
   output logic                                        out_valid,
   input  wire logic                                   out_ready,
   output logic [WEIGHT_BITS-1:0]                      out_nv,
   output ch_idx_type                                  out_tgt,
   output logic [WEIGHT_BITS+2:0]                      out_div,
   output logic [NUM_CH-1:0][2*WEIGHT_BITS-2:0]        out_prod
);

   localparam int SUM_BITS  = WEIGHT_BITS + 3;
   localparam int PROD_BITS = 2 * WEIGHT_BITS - 1;
   localparam logic [WEIGHT_BITS-1:0] W_ONE = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   // Stage A registers.
   logic                                 a_valid_ff;
   logic [WEIGHT_BITS-1:0]               a_nv_ff, a_nv_in;
   logic [WEIGHT_BITS-1:0]               a_remain_ff;
   ch_idx_type                           a_tgt_ff;
   logic [NUM_CH-1:0][WEIGHT_BITS-1:0]   a_w_ff, a_w_in;
   logic                                 a_ready;

   // Stage B registers.
   logic                                 b_valid_ff;
   logic [WEIGHT_BITS-1:0]               b_nv_ff;
   ch_idx_type                           b_tgt_ff;
   logic [SUM_BITS-1:0]                  b_div_ff, b_div_in;
   logic [NUM_CH-1:0][PROD_BITS-1:0]     b_prod_ff, b_prod_in;
   logic                                 b_ready;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   // The old weight of the target channel drops out of the sum and products.
   always_comb begin
      a_nv_in = (in_new_value > W_ONE) ? W_ONE : in_new_value;
      for (int i = 0; i < NUM_CH; i++) begin
         a_w_in[i] = (CH_BITS'(i) == in_tgt) ? '0 : in_weight[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= in_valid;
      end
      if (a_ready && in_valid) begin
         a_nv_ff     <= a_nv_in;
         a_remain_ff <= W_ONE - a_nv_in;
         a_tgt_ff    <= in_tgt;
         a_w_ff      <= a_w_in;
      end
   end

   always_comb begin
      logic [2*WEIGHT_BITS-1:0] full;
      b_div_in = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         b_div_in = b_div_in + SUM_BITS'(a_w_ff[i]);
      end
      for (int i = 0; i < NUM_CH; i++) begin
         full         = a_w_ff[i] * a_remain_ff;
         b_prod_in[i] = full[PROD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_nv_ff   <= a_nv_ff;
         b_tgt_ff  <= a_tgt_ff;
         b_div_ff  <= b_div_in;
         b_prod_ff <= b_prod_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_nv    = b_nv_ff;
   assign out_tgt   = b_tgt_ff;
   assign out_div   = b_div_ff;
   assign out_prod  = b_prod_ff;

endmodule

`default_nettype wire

[rtl/bwr_div_step.sv]
// One restoring division stage: one quotient bit for each of the eight lanes.
`default_nettype none

module bwr_div_step import bwr_pkg::*; #(
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         in_valid,
   output logic                                              in_ready,
   input  wire logic [WEIGHT_BITS-1:0]                       in_nv,
   input  wire ch_idx_type                                   in_tgt,
   input  wire logic [WEIGHT_BITS+2:0]                       in_div,
   input  wire logic [NUM_CH-1:0][2*WEIGHT_BITS+2:0]         in_acc,
   output logic                                              out_valid,
   input  wire logic                                         out_ready,
   output logic [WEIGHT_BITS-1:0]                            out_nv,
   output ch_idx_type                                        out_tgt,
   output logic [WEIGHT_BITS+2:0]                            out_div,
   output logic [NUM_CH-1:0][2*WEIGHT_BITS+2:0]              out_acc
);

   localparam int SUM_BITS = WEIGHT_BITS + 3;
   localparam int ACC_BITS = SUM_BITS + WEIGHT_BITS;

   logic                                 valid_ff;
   logic [WEIGHT_BITS-1:0]               nv_ff;
   ch_idx_type                           tgt_ff;
   logic [SUM_BITS-1:0]                  div_ff;
   logic [NUM_CH-1:0][ACC_BITS-1:0]      acc_ff, acc_in;

   assign in_ready = !valid_ff || out_ready;

   // The accumulator holds the partial remainder above the dividend bits not
   // yet consumed; quotient bits shift in at the bottom.
   always_comb begin
      logic [SUM_BITS:0] top;
      logic [SUM_BITS:0] diff;
      logic              ge;
      for (int i = 0; i < NUM_CH; i++) begin
         top  = in_acc[i][ACC_BITS-1:WEIGHT_BITS-1];
         diff = top - {1'b0, in_div};
         ge   = (top >= {1'b0, in_div});
         acc_in[i] = {(ge ? diff[SUM_BITS-1:0] : top[SUM_BITS-1:0]),
                      in_acc[i][WEIGHT_BITS-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         nv_ff  <= in_nv;
         tgt_ff <= in_tgt;
         div_ff <= in_div;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_nv    = nv_ff;
   assign out_tgt   = tgt_ff;
   assign out_div   = div_ff;
   assign out_acc   = acc_ff;

endmodule

`default_nettype wire

[rtl/blend_weight_renormalize.sv]
// Top level of the blend weight renormalizer: register, pipeline and output stage.
//
//   Port group   Direction  Handshake          Contents
//   req_*        in         req_valid/ready    new value and eight weights
//   rsp_*        out        rsp_valid/ready    eight balanced weights
//   csr_*        in         csr_wen            target channel
//
// A word can enter every cycle while the output is not stalled, and passes
// through two front stages, one divider stage per quotient bit and one output
// stage. Reset clears every valid bit and sets the target channel to zero.
// Each stage advances when the one after it is empty or moving, so a stalled
// output fills the bubbles behind it before req_ready drops.
`default_nettype none

module blend_weight_renormalize import bwr_pkg::*; #(
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wen,
   input  wire logic [CH_BITS-1:0]       csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [WEIGHT_BITS-1:0]   req_new_value,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_0,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_1,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_2,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_3,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_4,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_5,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_6,
   input  wire logic [WEIGHT_BITS-1:0]   req_weight_7,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_0,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_1,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_2,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_3,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_4,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_5,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_6,
   output logic [WEIGHT_BITS-1:0]        rsp_out_weight_7
);

   localparam int SUM_BITS  = WEIGHT_BITS + 3;
   localparam int PROD_BITS = 2 * WEIGHT_BITS - 1;
   localparam int ACC_BITS  = SUM_BITS + WEIGHT_BITS;

   ch_idx_type                           target_ff;
   logic [NUM_CH-1:0][WEIGHT_BITS-1:0]   req_w;

   logic                                 f_valid;
   logic [NUM_CH-1:0][PROD_BITS-1:0]     f_prod;

   logic                                 dv_valid [0:WEIGHT_BITS];
   logic                                 dv_ready [0:WEIGHT_BITS];
   logic [WEIGHT_BITS-1:0]               dv_nv    [0:WEIGHT_BITS];
   ch_idx_type                           dv_tgt   [0:WEIGHT_BITS];
   logic [SUM_BITS-1:0]                  dv_div   [0:WEIGHT_BITS];
   logic [NUM_CH-1:0][ACC_BITS-1:0]      dv_acc   [0:WEIGHT_BITS];

   logic                                 out_valid_ff;
   logic [NUM_CH-1:0][WEIGHT_BITS-1:0]   out_w_ff, out_w_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_wen) begin
         target_ff <= csr_wdata;
      end
   end

   assign req_w[0] = req_weight_0;
   assign req_w[1] = req_weight_1;
   assign req_w[2] = req_weight_2;
   assign req_w[3] = req_weight_3;
   assign req_w[4] = req_weight_4;
   assign req_w[5] = req_weight_5;
   assign req_w[6] = req_weight_6;
   assign req_w[7] = req_weight_7;

   bwr_front #(.WEIGHT_BITS(WEIGHT_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_tgt       (target_ff),
      .in_new_value (req_new_value),
      .in_weight    (req_w),
      .out_valid    (f_valid),
      .out_ready    (dv_ready[0]),
      .out_nv       (dv_nv[0]),
      .out_tgt      (dv_tgt[0]),
      .out_div      (dv_div[0]),
      .out_prod     (f_prod)
   );

   // The dividend enters zero-extended; the quotient fits in WEIGHT_BITS bits
   // because it never exceeds one minus the target.
   assign dv_valid[0] = f_valid;
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         dv_acc[0][i] = ACC_BITS'(f_prod[i]);
      end
   end

   for (genvar s = 0; s < WEIGHT_BITS; s++) begin : g_div
      bwr_div_step #(.WEIGHT_BITS(WEIGHT_BITS)) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[s]),
         .in_ready  (dv_ready[s]),
         .in_nv     (dv_nv[s]),
         .in_tgt    (dv_tgt[s]),
         .in_div    (dv_div[s]),
         .in_acc    (dv_acc[s]),
         .out_valid (dv_valid[s+1]),
         .out_ready (dv_ready[s+1]),
         .out_nv    (dv_nv[s+1]),
         .out_tgt   (dv_tgt[s+1]),
         .out_div   (dv_div[s+1]),
         .out_acc   (dv_acc[s+1])
      );
   end

   assign dv_ready[WEIGHT_BITS] = !out_valid_ff || rsp_ready;

   // A zero sum of the other weights forces them to zero.
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         if (CH_BITS'(i) == dv_tgt[WEIGHT_BITS]) begin
            out_w_in[i] = dv_nv[WEIGHT_BITS];
         end else if (dv_div[WEIGHT_BITS] == '0) begin
            out_w_in[i] = '0;
         end else begin
            out_w_in[i] = dv_acc[WEIGHT_BITS][i][WEIGHT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dv_ready[WEIGHT_BITS]) begin
         out_valid_ff <= dv_valid[WEIGHT_BITS];
      end
      if (dv_ready[WEIGHT_BITS] && dv_valid[WEIGHT_BITS]) begin
         out_w_ff <= out_w_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_weight_0 = out_w_ff[0];
   assign rsp_out_weight_1 = out_w_ff[1];
   assign rsp_out_weight_2 = out_w_ff[2];
   assign rsp_out_weight_3 = out_w_ff[3];
   assign rsp_out_weight_4 = out_w_ff[4];
   assign rsp_out_weight_5 = out_w_ff[5];
   assign rsp_out_weight_6 = out_w_ff[6];
   assign rsp_out_weight_7 = out_w_ff[7];

endmodule

`default_nettype wire
